/* rtl/ship_dip_rrip_replacement_defines.svh */
// Assertion macros used by the checker file of the replacement block.
`ifndef SHIP_DIP_RRIP_REPLACEMENT_DEFINES_SVH
`define SHIP_DIP_RRIP_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define SDRR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdrr assertion failed");

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define SDRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("sdrr assertion failed");

`endif

/* rtl/sdrr_pkg.sv */
`default_nettype none

package sdrr_pkg;

  // Default configuration of the replacement block.
  localparam int SETS_DEF        = 2048;
  localparam int WAYS_DEF        = 16;
  localparam int LEADER_SETS_DEF = 64;
  localparam int DUEL_BITS_DEF   = 10;
  localparam int SIG_WIDTH_DEF   = 4;

  // Fixed widths of the word fields.
  localparam int SET_IN_W   = 11;
  localparam int PC_W       = 6;
  localparam int WAY_IN_W   = 4;
  localparam int SIG_MAX_W  = 8;
  localparam int WAY_MAX_W  = 5;
  localparam int DEPTH_W    = 2;
  localparam int DUEL_OUT_W = 10;
  localparam int DUEL_EXT_W = 16;
  localparam int PHASE_W    = 5;

  // Compare-and-subtract steps for the modulo reductions. A set index below
  // 2048 is under 32 times the smallest set count, a way index below 16 is
  // under 8 times the smallest way count.
  localparam int SET_STEPS = 5;
  localparam int WAY_STEPS = 3;

  // Two-bit codes for prediction values and reuse counters.
  localparam logic [1:0] RRPV_FAR   = 2'd3;
  localparam logic [1:0] RRPV_NEAR  = 2'd0;
  localparam logic [1:0] REUSE_MAX  = 2'd3;
  localparam logic [1:0] REUSE_INIT = 2'd1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } sdrr_state_e;

  // One accepted access, already reduced to the configured geometry.
  typedef struct packed {
    logic [SET_IN_W-1:0]  set_idx;
    logic [SIG_MAX_W-1:0] sig;
    logic                 hit;
    logic [WAY_IN_W-1:0]  way;
  } sdrr_item_t;

  // Way and prediction value chosen for one access.
  typedef struct packed {
    logic [WAY_MAX_W-1:0] way;
    logic [DEPTH_W-1:0]   depth;
  } sdrr_res_t;

  // Width of one per-set row: prediction values, signatures, reuse counters.
  function automatic int sdrr_row_w(int ways, int sig_width);
    return 2 * ways + sig_width * ways + 2 * (1 << sig_width);
  endfunction

  // Remainder by restoring compare and subtract, valid when x < m << steps.
  function automatic logic [31:0] sdrr_reduce(logic [31:0] x, int m, int steps);
    logic [31:0] r;
    logic [31:0] sub;
    r = x;
    for (int k = steps - 1; k >= 0; k--) begin
      sub = 32'(m) << k;
      if (r >= sub) begin
        r = r - sub;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/sdrr_mem.sv */
`default_nettype none

module sdrr_mem #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/sdrr_update.sv */
`default_nettype none

module sdrr_update import sdrr_pkg::*; #(
  parameter int WAYS        = WAYS_DEF,
  parameter int LEADER_SETS = LEADER_SETS_DEF,
  parameter int DUEL_BITS   = DUEL_BITS_DEF,
  parameter int SIG_WIDTH   = SIG_WIDTH_DEF
) (
  input  wire logic [sdrr_row_w(WAYS, SIG_WIDTH)-1:0] row_i,
  input  wire sdrr_item_t                             item_i,
  input  wire logic [DUEL_BITS-1:0]                   duel_i,
  input  wire logic [PHASE_W-1:0]                     phase_i,
  output logic      [sdrr_row_w(WAYS, SIG_WIDTH)-1:0] row_o,
  output sdrr_res_t                                   res_o,
  output logic      [DUEL_BITS-1:0]                   duel_o,
  output logic      [PHASE_W-1:0]                     phase_o
);

  localparam int WAY_W     = $clog2(WAYS);
  localparam int SIG_COUNT = 1 << SIG_WIDTH;
  localparam int RRPV_W    = 2 * WAYS;
  localparam int SIGS_W    = SIG_WIDTH * WAYS;
  localparam int LIP_END   = LEADER_SETS / 2;
  localparam logic [DUEL_BITS-1:0] DUEL_MID = {1'b0, {(DUEL_BITS-1){1'b1}}};
  localparam logic [DUEL_BITS-1:0] DUEL_MAX = {DUEL_BITS{1'b1}};
  localparam logic [DUEL_BITS-1:0] DUEL_MIN = '0;

  logic [1:0]           rrpv_in  [WAYS];
  logic [SIG_WIDTH-1:0] sig_in   [WAYS];
  logic [1:0]           reuse_in [SIG_COUNT];
  logic [1:0]           rrpv_n   [WAYS];
  logic [SIG_WIDTH-1:0] sig_n    [WAYS];
  logic [1:0]           reuse_n  [SIG_COUNT];

  logic                 lip_lead;
  logic                 bip_lead;
  logic                 use_lip;
  logic [SIG_WIDTH-1:0] new_sig;
  logic [SIG_WIDTH-1:0] sel_sig;
  logic [1:0]           cur_reuse;
  logic                 has3, has2, has1;
  logic [1:0]           top;
  logic [1:0]           age_add;
  logic [WAY_W-1:0]     victim;
  logic [WAY_W-1:0]     hway;
  logic [DEPTH_W-1:0]   depth;

  // Split the row into its fields.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rrpv_in[w] = row_i[2*w +: 2];
      sig_in[w]  = row_i[RRPV_W + w*SIG_WIDTH +: SIG_WIDTH];
    end
    for (int s = 0; s < SIG_COUNT; s++) begin
      reuse_in[s] = row_i[RRPV_W + SIGS_W + 2*s +: 2];
    end
  end

  // Policy selection from the set's role in the duel.
  assign lip_lead  = 32'(item_i.set_idx) < 32'(LIP_END);
  assign bip_lead  = !lip_lead && (32'(item_i.set_idx) < 32'(LEADER_SETS));
  assign use_lip   = lip_lead || (!bip_lead && (duel_i < DUEL_MID));
  assign new_sig   = item_i.sig[SIG_WIDTH-1:0];
  assign cur_reuse = reuse_in[new_sig];
  assign hway      = WAY_W'(item_i.way);

  // Victim search: the largest prediction value present, lowest way holding it.
  always_comb begin
    has3   = 1'b0;
    has2   = 1'b0;
    has1   = 1'b0;
    victim = '0;
    for (int w = 0; w < WAYS; w++) begin
      has3 = has3 | (rrpv_in[w] == 2'd3);
      has2 = has2 | (rrpv_in[w] == 2'd2);
      has1 = has1 | (rrpv_in[w] == 2'd1);
    end
    top = has3 ? 2'd3 : (has2 ? 2'd2 : (has1 ? 2'd1 : 2'd0));
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rrpv_in[w] == top) begin
        victim = WAY_W'(w);
      end
    end
    age_add = RRPV_FAR - top;
  end

  // Row update, insertion depth and duel bookkeeping.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rrpv_n[w] = rrpv_in[w];
      sig_n[w]  = sig_in[w];
    end
    for (int s = 0; s < SIG_COUNT; s++) begin
      reuse_n[s] = reuse_in[s];
    end
    duel_o  = duel_i;
    phase_o = phase_i;
    sel_sig = '0;

    // Signature-guided depth, overridden by the leader policies.
    if (cur_reuse >= 2'd2) begin
      depth = 2'd1;
    end else if (cur_reuse == 2'd1) begin
      depth = 2'd2;
    end else begin
      depth = 2'd3;
    end
    if (use_lip) begin
      depth = RRPV_FAR;
    end else if (bip_lead) begin
      depth   = (phase_i == '0) ? RRPV_NEAR : RRPV_FAR;
      phase_o = phase_i + 1'b1;
    end

    if (item_i.hit) begin
      // Promote the way and credit the signature that filled it.
      rrpv_n[hway] = RRPV_NEAR;
      sel_sig      = sig_in[hway];
      if (reuse_in[sel_sig] != REUSE_MAX) begin
        reuse_n[sel_sig] = reuse_in[sel_sig] + 2'd1;
      end
      if (lip_lead) begin
        if (duel_i != DUEL_MAX) begin
          duel_o = duel_i + 1'b1;
        end
      end else if (bip_lead) begin
        if (duel_i != DUEL_MIN) begin
          duel_o = duel_i - 1'b1;
        end
      end
      depth      = RRPV_NEAR;
      res_o.way  = WAY_MAX_W'(hway);
    end else begin
      // Age the set, penalize the evicted signature and insert the new one.
      for (int w = 0; w < WAYS; w++) begin
        rrpv_n[w] = rrpv_in[w] + age_add;
      end
      sel_sig = sig_in[victim];
      if (reuse_in[sel_sig] != 2'd0) begin
        reuse_n[sel_sig] = reuse_in[sel_sig] - 2'd1;
      end
      sig_n[victim]  = new_sig;
      rrpv_n[victim] = depth;
      res_o.way      = WAY_MAX_W'(victim);
    end
    res_o.depth = depth;
  end

  // Reassemble the row for write-back.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_o[2*w +: 2]                            = rrpv_n[w];
      row_o[RRPV_W + w*SIG_WIDTH +: SIG_WIDTH]   = sig_n[w];
    end
    for (int s = 0; s < SIG_COUNT; s++) begin
      row_o[RRPV_W + SIGS_W + 2*s +: 2] = reuse_n[s];
    end
  end

endmodule

`default_nettype wire

/* rtl/ship_dip_rrip_replacement.sv */
// Flow: a word accepted in the idle state has its row read into the memory's read
// register, and its result is registered once the output register is free. A new
// word is taken only after the read and then write-back of its per-set row.
// Reset: asynchronous, active low; afterwards a clearing pass writes every row
// of the state memory (SETS rows, 2048 by default), with input stalled.
`default_nettype none

module ship_dip_rrip_replacement import sdrr_pkg::*; #(
  parameter int SETS        = SETS_DEF,
  parameter int WAYS        = WAYS_DEF,
  parameter int LEADER_SETS = LEADER_SETS_DEF,
  parameter int DUEL_BITS   = DUEL_BITS_DEF,
  parameter int SIG_WIDTH   = SIG_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [SET_IN_W-1:0]   set_index_i,
  input  wire logic [PC_W-1:0]       pc_low_i,
  input  wire logic                  hit_flag_i,
  input  wire logic [WAY_IN_W-1:0]   hit_way_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [WAY_IN_W-1:0]   chosen_way_o,
  output logic      [DEPTH_W-1:0]    insert_depth_o,
  output logic      [DUEL_OUT_W-1:0] duel_value_o
);

  localparam int ADDR_W    = $clog2(SETS);
  localparam int ROW_W     = sdrr_row_w(WAYS, SIG_WIDTH);
  localparam int SIG_COUNT = 1 << SIG_WIDTH;
  localparam logic [ROW_W-1:0] CLEAR_ROW =
    {{SIG_COUNT{REUSE_INIT}}, {(SIG_WIDTH*WAYS){1'b0}}, {WAYS{RRPV_FAR}}};
  localparam logic [DUEL_BITS-1:0] DUEL_MID  = {1'b0, {(DUEL_BITS-1){1'b1}}};
  localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(SETS - 1);

  sdrr_state_e            state_q, state_d;
  logic [ADDR_W-1:0]      clr_cnt_q, clr_cnt_d;
  sdrr_item_t             item_q, in_item;
  logic [DUEL_BITS-1:0]   duel_q, duel_nxt;
  logic [PHASE_W-1:0]     phase_q, phase_nxt;
  logic                   out_valid_q, out_valid_d;
  logic [WAY_IN_W-1:0]    chosen_way_q;
  logic [DEPTH_W-1:0]     insert_depth_q;
  logic [DUEL_OUT_W-1:0]  duel_value_q;

  logic                   in_acc;
  logic                   upd_go;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [ROW_W-1:0]       mem_wdata;
  logic [ROW_W-1:0]       rd_row;
  logic [ROW_W-1:0]       new_row;
  sdrr_res_t              upd_res;
  logic [31:0]            set_red;
  logic [31:0]            way_red;
  logic [DUEL_EXT_W-1:0]  duel_ext;

  // Reduce the incoming word to the configured geometry and form its signature.
  always_comb begin
    set_red         = sdrr_reduce(32'(set_index_i), SETS, SET_STEPS);
    way_red         = sdrr_reduce(32'(hit_way_i), WAYS, WAY_STEPS);
    in_item.set_idx = set_red[SET_IN_W-1:0];
    in_item.sig     = SIG_MAX_W'(pc_low_i[PC_W-1:2]) ^ set_red[SIG_MAX_W-1:0];
    in_item.hit     = hit_flag_i;
    in_item.way     = way_red[WAY_IN_W-1:0];
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign upd_go     = (state_q == ST_UPDATE) && (!out_valid_q || !out_stall_i);

  // Per-set state: one row read on accept, written back once the result
  // register is free.
  sdrr_mem #(
    .DEPTH (SETS),
    .WIDTH (ROW_W)
  ) u_sdrr_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (in_acc),
    .rd_addr_i (ADDR_W'(in_item.set_idx)),
    .rd_data_o (rd_row)
  );

  // Row modification and policy decision.
  sdrr_update #(
    .WAYS        (WAYS),
    .LEADER_SETS (LEADER_SETS),
    .DUEL_BITS   (DUEL_BITS),
    .SIG_WIDTH   (SIG_WIDTH)
  ) u_sdrr_update (
    .row_i   (rd_row),
    .item_i  (item_q),
    .duel_i  (duel_q),
    .phase_i (phase_q),
    .row_o   (new_row),
    .res_o   (upd_res),
    .duel_o  (duel_nxt),
    .phase_o (phase_nxt)
  );

  // Sequencer: clearing pass, then accept and write back one word at a time.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = CLEAR_ROW;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(item_q.set_idx);
          mem_wdata = new_row;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Output valid: set when a result is produced, cleared once taken.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (upd_go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      duel_q      <= DUEL_MID;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (upd_go) begin
        duel_q  <= duel_nxt;
        phase_q <= phase_nxt;
      end
    end
  end

  // Accepted word and result payload.
  assign duel_ext = DUEL_EXT_W'(duel_nxt);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item;
    end
    if (upd_go) begin
      chosen_way_q   <= upd_res.way[WAY_IN_W-1:0];
      insert_depth_q <= upd_res.depth;
      duel_value_q   <= duel_ext[DUEL_OUT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chosen_way_o   = chosen_way_q;
  assign insert_depth_o = insert_depth_q;
  assign duel_value_o   = duel_value_q;

endmodule

`default_nettype wire

/* rtl/sdrr_checker.sv */
`default_nettype none

`include "ship_dip_rrip_replacement_defines.svh"

module sdrr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       hit_flag_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [3:0] chosen_way_o,
  input wire logic [1:0] insert_depth_o,
  input wire logic [9:0] duel_value_o
);

  // One word at a time: an accepted word blocks the input for the next cycle.
  `SDRR_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o)

  // A new result only follows a cycle spent on write-back with input stalled.
  `SDRR_ASSERT_IMPL(a_result_after_work, out_valid_o && !$past(out_valid_o), $past(in_stall_o))

  // A hit accepted with the output free passes through the update state and shows depth zero.
  `SDRR_ASSERT_NEXT(a_hit_depth, in_valid_i && !in_stall_o && hit_flag_i && !out_valid_o, ##1 (out_valid_o && insert_depth_o == 2'd0))

  // A stalled result word holds.
  `SDRR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, (out_valid_o && $stable(chosen_way_o) && $stable(insert_depth_o) && $stable(duel_value_o)))

endmodule

bind ship_dip_rrip_replacement sdrr_checker u_sdrr_checker (.*);

`default_nettype wire

/* tb/ship_dip_rrip_replacement_tb.sv */
`timescale 1ns / 100ps
`default_nettype none

module ship_dip_rrip_replacement_tb;
  import sdrr_pkg::*;

  localparam int SIG_COUNT   = 1 << SIG_WIDTH_DEF;
  localparam int DUEL_TOP    = (1 << DUEL_BITS_DEF) - 1;
  localparam int DUEL_MIDDLE = DUEL_TOP / 2;
  localparam int LIP_LIMIT   = LEADER_SETS_DEF / 2;

  // Random part: the first stretch drives the duel counter up, the rest down.
  localparam int RANDOM_WORDS = 1280;
  localparam int RISE_WORDS   = 650;
  localparam int QUIET_WORDS  = 130;
  localparam int DRAIN_CYCLES = 16;

  // One access word and the replacement decision it produces.
  typedef struct packed {
    logic [SET_IN_W-1:0] set_idx;
    logic [PC_W-1:0]     pc;
    logic                hit;
    logic [WAY_IN_W-1:0] way;
  } access_t;

  typedef struct packed {
    logic [WAY_IN_W-1:0]   way;
    logic [DEPTH_W-1:0]    depth;
    logic [DUEL_OUT_W-1:0] duel;
  } decision_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [SET_IN_W-1:0]   set_index_i    = '0;
  logic [PC_W-1:0]       pc_low_i       = '0;
  logic                  hit_flag_i     = 1'b0;
  logic [WAY_IN_W-1:0]   hit_way_i      = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [WAY_IN_W-1:0]   chosen_way_o;
  logic [DEPTH_W-1:0]    insert_depth_o;
  logic [DUEL_OUT_W-1:0] duel_value_o;

  ship_dip_rrip_replacement u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .set_index_i    (set_index_i),
    .pc_low_i       (pc_low_i),
    .hit_flag_i     (hit_flag_i),
    .hit_way_i      (hit_way_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chosen_way_o   (chosen_way_o),
    .insert_depth_o (insert_depth_o),
    .duel_value_o   (duel_value_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Shadow copy of the replacement state.
  logic [1:0]               line_rrpv  [SETS_DEF][WAYS_DEF];
  logic [SIG_WIDTH_DEF-1:0] line_sig   [SETS_DEF][WAYS_DEF];
  logic [1:0]               set_reuse  [SETS_DEF][SIG_COUNT];
  logic [DUEL_BITS_DEF-1:0] duel_level;
  logic [PHASE_W-1:0]       bip_step;

  access_t   pending_words[$];
  decision_t expected_decisions[$];
  access_t   word_on_bus;
  int        fail_count = 0;
  int        send_gap   = 0;
  int        send_calm  = 0;
  int        recv_gap   = 0;
  int        recv_calm  = 0;

  int unsigned lip_sets[4]    = '{0, 1, 17, 31};
  int unsigned bip_sets[4]    = '{32, 33, 48, 63};
  int unsigned follow_sets[4] = '{64, 700, 1025, 2047};

  // Work out the decision for one accepted word and update the shadow state.
  task automatic predict_replacement(input access_t a);
    int unsigned              s;
    int unsigned              w_sel;
    logic [SIG_WIDTH_DEF-1:0] sig_new;
    logic [SIG_WIDTH_DEF-1:0] sig_old;
    logic [1:0]               reuse_new;
    logic [1:0]               top;
    bit                       lip_lead;
    bit                       bip_lead;
    bit                       use_lip;
    logic [DEPTH_W-1:0]       depth;
    decision_t                d;
    s         = a.set_idx % SETS_DEF;
    w_sel     = a.way % WAYS_DEF;
    sig_new   = SIG_WIDTH_DEF'((a.pc >> 2) ^ s);
    reuse_new = set_reuse[s][sig_new];
    lip_lead  = s < LIP_LIMIT;
    bip_lead  = !lip_lead && s < LEADER_SETS_DEF;
    use_lip   = lip_lead || (!bip_lead && duel_level < DUEL_MIDDLE);

    // Signature-guided depth, then overridden by the leader policies.
    if (reuse_new >= 2) begin
      depth = 2'd1;
    end else if (reuse_new == 1) begin
      depth = 2'd2;
    end else begin
      depth = RRPV_FAR;
    end
    if (use_lip) begin
      depth = RRPV_FAR;
    end else if (bip_lead) begin
      depth = (bip_step == 0) ? RRPV_NEAR : RRPV_FAR;
      bip_step = bip_step + 1'b1;
    end

    if (a.hit) begin
      sig_old = line_sig[s][w_sel];
      line_rrpv[s][w_sel] = RRPV_NEAR;
      if (set_reuse[s][sig_old] < REUSE_MAX) begin
        set_reuse[s][sig_old] = set_reuse[s][sig_old] + 1'b1;
      end
      if (lip_lead && duel_level < DUEL_TOP) begin
        duel_level = duel_level + 1'b1;
      end else if (bip_lead && duel_level > 0) begin
        duel_level = duel_level - 1'b1;
      end
      depth = RRPV_NEAR;
    end else begin
      // Victim: the first way holding the largest value; age the set up to far.
      top   = line_rrpv[s][0];
      w_sel = 0;
      for (int w = 1; w < WAYS_DEF; w++) begin
        if (line_rrpv[s][w] > top) begin
          top   = line_rrpv[s][w];
          w_sel = w;
        end
      end
      if (top < RRPV_FAR) begin
        for (int w = 0; w < WAYS_DEF; w++) begin
          line_rrpv[s][w] = line_rrpv[s][w] + (RRPV_FAR - top);
        end
      end
      sig_old = line_sig[s][w_sel];
      if (set_reuse[s][sig_old] > 0) begin
        set_reuse[s][sig_old] = set_reuse[s][sig_old] - 1'b1;
      end
      line_sig[s][w_sel]  = sig_new;
      line_rrpv[s][w_sel] = depth;
    end

    d.way   = WAY_IN_W'(w_sel);
    d.depth = depth;
    d.duel  = DUEL_OUT_W'(duel_level);
    expected_decisions.push_back(d);
  endtask

  task automatic add_access(input int unsigned s, input int unsigned pc, input bit hit,
                            input int unsigned way);
    access_t a;
    a.set_idx = SET_IN_W'(s);
    a.pc      = PC_W'(pc);
    a.hit     = hit;
    a.way     = WAY_IN_W'(way);
    pending_words.push_back(a);
  endtask

  // Mostly a few signature groups so that reuse counters build up.
  function automatic int unsigned draw_pc();
    if ($urandom_range(0, 9) < 7) begin
      return ($urandom_range(0, 3) << 2) | $urandom_range(0, 3);
    end
    return $urandom_range(0, 63);
  endfunction

  // Low ways are the ones filled first, so hits lean toward them.
  function automatic int unsigned draw_way();
    if ($urandom_range(0, 9) < 6) begin
      return $urandom_range(0, 3);
    end
    return $urandom_range(0, 15);
  endfunction

  // Length of the next idle burst; calm stretches have none.
  function automatic int draw_burst(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if ($urandom_range(0, 4) == 0) begin
      return $urandom_range(1, 14);
    end
    return 0;
  endfunction

  // Driver: presents pending words and predicts each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      set_index_i <= '0;
      pc_low_i    <= '0;
      hit_flag_i  <= 1'b0;
      hit_way_i   <= '0;
      send_gap    = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_replacement(word_on_bus);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap == 0 && pending_words.size() > QUIET_WORDS) begin
          send_gap = draw_burst(send_calm);
        end
        if (send_gap > 0 || pending_words.size() == 0) begin
          if (send_gap > 0) begin
            send_gap--;
          end
          in_valid_i <= 1'b0;
        end else begin
          word_on_bus = pending_words.pop_front();
          in_valid_i  <= 1'b1;
          set_index_i <= word_on_bus.set_idx;
          pc_low_i    <= word_on_bus.pc;
          hit_flag_i  <= word_on_bus.hit;
          hit_way_i   <= word_on_bus.way;
        end
      end
    end
  end

  // Monitor: checks each accepted result word and stalls in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    decision_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap    = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_decisions.size() == 0) begin
          $error("unexpected result word: chosen_way %0d insert_depth %0d duel_value %0d",
                 chosen_way_o, insert_depth_o, duel_value_o);
          fail_count++;
        end else begin
          want = expected_decisions.pop_front();
          if (chosen_way_o !== want.way) begin
            $error("chosen_way: expected %0d actual %0d", want.way, chosen_way_o);
            fail_count++;
          end
          if (insert_depth_o !== want.depth) begin
            $error("insert_depth: expected %0d actual %0d", want.depth, insert_depth_o);
            fail_count++;
          end
          if (duel_value_o !== want.duel) begin
            $error("duel_value: expected %0d actual %0d", want.duel, duel_value_o);
            fail_count++;
          end
        end
      end
      if (recv_gap == 0 && pending_words.size() > QUIET_WORDS) begin
        recv_gap = draw_burst(recv_calm);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned roll;
    int unsigned lead_set;

    for (int s = 0; s < SETS_DEF; s++) begin
      for (int w = 0; w < WAYS_DEF; w++) begin
        line_rrpv[s][w] = RRPV_FAR;
        line_sig[s][w]  = '0;
      end
      for (int g = 0; g < SIG_COUNT; g++) begin
        set_reuse[s][g] = REUSE_INIT;
      end
    end
    duel_level = DUEL_BITS_DEF'(DUEL_MIDDLE);
    bip_step   = '0;

    // Insertion-leader miss and hits at the extremes of the hit way.
    add_access(0, 0, 1'b0, 0);
    add_access(0, 63, 1'b1, 0);
    add_access(31, 0, 1'b1, 15);
    // Bimodal-leader misses: the phase-zero fill lands near, the next far.
    add_access(32, 0, 1'b0, 0);
    add_access(32, 4, 1'b0, 9);
    add_access(63, 0, 1'b1, 15);
    // Follower set with the counter above the midpoint: signature-guided depth.
    add_access(64, 0, 1'b0, 0);
    add_access(64, 0, 1'b1, 0);
    add_access(64, 0, 1'b1, 0);
    add_access(64, 0, 1'b0, 0);
    // A penalized signature drops to zero reuse and inserts far.
    add_access(100, 0, 1'b0, 0);
    add_access(100, 16, 1'b0, 0);
    add_access(2047, 63, 1'b0, 15);
    add_access(2047, 63, 1'b1, 15);
    add_access(1024, 32, 1'b0, 7);
    // Drop the duel counter below the midpoint so followers switch to LIP.
    add_access(63, 12, 1'b1, 3);
    add_access(40, 44, 1'b1, 7);
    add_access(64, 8, 1'b0, 0);
    add_access(65, 60, 1'b1, 15);
    add_access(2046, 3, 1'b0, 5);

    // Random part: leader hits steer the duel, the rest varies the sets.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      roll     = $urandom_range(0, 99);
      lead_set = (n < RISE_WORDS) ? lip_sets[$urandom_range(0, 3)]
                                  : bip_sets[$urandom_range(0, 3)];
      if (roll < 85) begin
        add_access(lead_set, draw_pc(), 1'b1, draw_way());
      end else if (roll < 94) begin
        add_access(follow_sets[$urandom_range(0, 3)], draw_pc(),
                   $urandom_range(0, 9) < 4, draw_way());
      end else if (roll < 96) begin
        add_access(bip_sets[$urandom_range(0, 3)], draw_pc(), 1'b0, draw_way());
      end else if (roll < 97) begin
        add_access(lip_sets[$urandom_range(0, 3)], draw_pc(), 1'b0, draw_way());
      end else begin
        add_access($urandom_range(0, 2047), $urandom_range(0, 63),
                   $urandom_range(0, 1), $urandom_range(0, 15));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() > 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (expected_decisions.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && expected_decisions.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run, clearing pass included.
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* ship_dip_rrip_replacement.f */
+incdir+rtl
rtl/sdrr_pkg.sv
rtl/sdrr_mem.sv
rtl/sdrr_update.sv
rtl/ship_dip_rrip_replacement.sv
rtl/sdrr_checker.sv
tb/ship_dip_rrip_replacement_tb.sv
